// File: design/ejt_pkg.sv
// ----------------------------------------------------------------------------
// ejt_pkg: shared constants for the elastic joint torque pipeline
// Fixed-point constants, register indexes, mode codes and stage counts.
// ----------------------------------------------------------------------------
`default_nettype none

package ejt_pkg;

  // default number of fraction bits on the ports
  localparam int FRAC_BITS_DEF = 16;

  // internal fraction bits of the exp unit
  localparam int INT_Q = 24;
  localparam logic [50:0] ROUND24 = 51'd1 << (INT_Q - 1);

  // 6.7328, ln 2, 0.0222 and 6.7328*0.0222 in Q24
  localparam logic [26:0] K_A   = 27'd112957640;
  localparam logic [23:0] K_LN2 = 24'd11629080;
  localparam logic [18:0] K_K   = 19'd372454;
  localparam logic [21:0] K_AK  = 22'd2507660;

  // multiples of ln 2 for the range reduction
  localparam logic [26:0] LN2_MULT [0:7] = '{
    27'd0, 27'd11629080, 27'd23258160, 27'd34887240,
    27'd46516320, 27'd58145400, 27'd69774480, 27'd81403560
  };

  // ceil(2^30 / k): exact floor division by k for values below 2^25
  localparam int RECIP_SHIFT = 30;
  localparam logic [30:0] DIV_RECIP [1:12] = '{
    31'd1073741824, 31'd536870912, 31'd357913942, 31'd268435456,
    31'd214748365, 31'd178956971, 31'd153391690, 31'd134217728,
    31'd119304648, 31'd107374183, 31'd97612894,  31'd89478486
  };

  localparam int TAYLOR_TERMS = 12;
  localparam int DIV_STEPS    = 25;
  // range reduction 3, Taylor 2 per term, sum 1, divider, tail 5
  localparam int SPRING_LAT   = 3 + 2 * TAYLOR_TERMS + 1 + DIV_STEPS + 5;

  // register indexes
  localparam logic REG_CONTROL_MODE = 1'b0;
  localparam logic REG_DAMPING_GAIN = 1'b1;

  // control modes
  localparam logic [1:0] MODE_MOTOR     = 2'd0;
  localparam logic [1:0] MODE_EQUIL     = 2'd1;
  localparam logic [1:0] MODE_DIRECT    = 2'd2;
  localparam logic [1:0] MODE_MOTOR_ALT = 2'd3;

  // front-end occupancy handed to the top level
  typedef struct packed {
    logic [1:0] inflight;
  } front_stat_t;

endpackage

`default_nettype wire

// File: design/elastic_joint_torque_model.sv
// ----------------------------------------------------------------------------
// elastic_joint_torque_model: two-spring elastic joint torque model
// Channel    Dir  Bits  Contents
// s_axis     in   160   position, velocity, reference one/two, external torque
// m_axis     out  160   applied force, joint torque, stiffness, spring torques
// cfg        in   31    control_mode (index 0), damping_gain (index 1)
//
// One word per cycle sustained while the output takes words. From the
// accepting edge to a valid result word: two front stages, the queue write,
// the spring lanes (exp Taylor terms and a 25-step reciprocal, 58 stages)
// and two output stages. Synchronous reset clears control state and the held
// spring values; no clearing pass. A stalled output freezes the back pipeline;
// the front keeps accepting while the four-entry queue has room.
// ----------------------------------------------------------------------------
`default_nettype none

module elastic_joint_torque_model import ejt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // joint_position, joint_velocity, reference_one, reference_two,
  // external_torque (32 bits each, from bit 0 up)
  input  logic [159:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // applied_force, joint_torque, joint_stiffness, spring_torque_one,
  // spring_torque_two (32 bits each, from bit 0 up)
  output logic [159:0] m_axis_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [30:0]  cfg_wdata
);

  localparam int QDEPTH = 4;
  localparam int CW     = $clog2(QDEPTH + 1);
  localparam int QW     = 1 + 2 * (FRAC_BITS + 1) + (63 - FRAC_BITS) + 64;

  // configuration registers
  logic [1:0]  control_mode;
  logic [30:0] damping_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      control_mode <= MODE_MOTOR;
      damping_gain <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CONTROL_MODE: control_mode <= cfg_wdata[1:0];
        REG_DAMPING_GAIN: damping_gain <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic          accept, push, pop;
  logic [QW-1:0] push_data, head;
  logic [CW-1:0] count;
  front_stat_t   fstat;

  // room for every word already in flight
  assign s_axis_tready = (CW'(count) + CW'(fstat.inflight)) < CW'(QDEPTH);
  assign accept        = s_axis_tvalid && s_axis_tready;

  ejt_front #(.FRAC_BITS(FRAC_BITS), .QW(QW)) u_front (
    .clk(clk), .rst(rst), .accept(accept), .word_in(s_axis_tdata),
    .control_mode(control_mode), .damping_gain(damping_gain),
    .push(push), .push_data(push_data), .stat(fstat)
  );

  ejt_queue #(.W(QW), .DEPTH(QDEPTH)) u_queue (
    .clk(clk), .rst(rst), .push(push), .din(push_data),
    .pop(pop), .dout(head), .count(count)
  );

  ejt_back #(.FRAC_BITS(FRAC_BITS), .QW(QW)) u_back (
    .clk(clk), .rst(rst), .head_valid(count != '0), .head(head), .pop(pop),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_word(m_axis_tdata)
  );

endmodule

`default_nettype wire

// File: design/ejt_front.sv
// ----------------------------------------------------------------------------
// ejt_front: input classification
// Resolves motor references, clamps both deflections and forms the damping
// term; two register stages ahead of the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ejt_front import ejt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int QW = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [159:0]      word_in,
  input  logic [1:0]        control_mode,
  input  logic [30:0]       damping_gain,
  output logic              push,
  output logic [QW-1:0]     push_data,
  output front_stat_t       stat
);

  localparam int DAMP_W = 63 - FRAC_BITS;
  localparam int DW     = FRAC_BITS + 1;
  localparam int DMAX   = (4 * (1 << FRAC_BITS) + 2) / 5;
  localparam logic [61:0] HALF_F = 62'd1 << (FRAC_BITS - 1);

  logic signed [31:0] q_in, dq_in, r1_in, r2_in, ext_in;
  logic [31:0]        mdq;

  assign q_in   = word_in[31:0];
  assign dq_in  = word_in[63:32];
  assign r1_in  = word_in[95:64];
  assign r2_in  = word_in[127:96];
  assign ext_in = word_in[159:128];
  assign mdq    = dq_in[31] ? 32'(-dq_in) : 32'(dq_in);

  // stage A
  logic               va, direct_a, dqn_a;
  logic signed [31:0] q_a, r1_a, ext_a;
  logic signed [32:0] th1_a, th2_a;
  logic [61:0]        prod_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else begin
      va <= accept;
    end
  end

  always_ff @(posedge clk) begin
    direct_a <= (control_mode == MODE_DIRECT);
    q_a      <= q_in;
    r1_a     <= r1_in;
    ext_a    <= ext_in;
    dqn_a    <= dq_in[31];
    prod_a   <= 62'(damping_gain) * 62'(mdq);
    if (control_mode == MODE_EQUIL) begin
      th1_a <= 33'(r1_in) + 33'(r2_in);
      th2_a <= 33'(r1_in) - 33'(r2_in);
    end else begin
      th1_a <= 33'(r1_in);
      th2_a <= 33'(r2_in);
    end
  end

  // clamp to the deflection bound
  function automatic logic signed [DW-1:0] clampd(input logic signed [33:0] d);
    logic signed [33:0] lim;
    lim = 34'(DMAX);
    if (d > lim) return DW'(lim);
    if (d < -lim) return DW'(-lim);
    return DW'(d);
  endfunction

  // stage B
  logic                     vb, direct_b;
  logic signed [DW-1:0]     d1_b, d2_b;
  logic signed [DAMP_W-1:0] damp_b;
  logic signed [31:0]       r1_b, ext_b;
  logic [DAMP_W-2:0]        dmag;

  assign dmag = (DAMP_W-1)'((prod_a + HALF_F) >> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    direct_b <= direct_a;
    d1_b     <= clampd(34'(q_a) - 34'(th1_a));
    d2_b     <= clampd(34'(q_a) - 34'(th2_a));
    damp_b   <= dqn_a ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag});
    r1_b     <= r1_a;
    ext_b    <= ext_a;
  end

  assign push          = vb;
  assign push_data     = {direct_b, d1_b, d2_b, damp_b, r1_b, ext_b};
  assign stat.inflight = {1'b0, va} + {1'b0, vb};

endmodule

`default_nettype wire

// File: design/ejt_queue.sv
// ----------------------------------------------------------------------------
// ejt_queue: short word queue between front and back
// Register FIFO with a head read and an occupancy count.
// ----------------------------------------------------------------------------
`default_nettype none

module ejt_queue import ejt_pkg::*; #(
  parameter int W = 1,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [W-1:0]               din,
  input  logic                       pop,
  output logic [W-1:0]               dout,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  slots [0:DEPTH-1];
  logic [AW-1:0] wptr, rptr;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    if (p == AW'(DEPTH - 1)) return '0;
    return p + AW'(1);
  endfunction

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= bump(wptr);
      if (pop)  rptr <= bump(rptr);
      count <= count + CW'(push) - CW'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= din;
  end

  assign dout = slots[rptr];

endmodule

`default_nettype wire

// File: design/ejt_spring.sv
// ----------------------------------------------------------------------------
// ejt_spring: nonlinear spring lane
// Torque -0.0222*sinh(6.7328*d) and stiffness from cosh, through range
// reduction, a pipelined Taylor exp and a pipelined reciprocal.
// ----------------------------------------------------------------------------
`default_nettype none

module ejt_spring import ejt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [FRAC_BITS:0] defl,
  output logic signed [31:0]      tau,
  output logic [31:0]             stiff
);

  localparam int SH_DOWN = INT_Q - FRAC_BITS;
  localparam int HALF    = (1 << SH_DOWN) >> 1;
  localparam int NT      = TAYLOR_TERMS;
  localparam int ND      = DIV_STEPS;

  // S0: magnitude to Q24 and scale by 6.7328
  logic [FRAC_BITS-1:0] mag;
  logic [23:0]          m0;
  logic                 neg_s0, neg_s1;
  logic [50:0]          px_s0;
  logic [26:0]          x_s1;

  assign mag = defl[FRAC_BITS] ? FRAC_BITS'(-defl) : defl[FRAC_BITS-1:0];
  assign m0  = 24'(mag) << SH_DOWN;

  always_ff @(posedge clk) begin
    if (en) begin
      neg_s0 <= defl[FRAC_BITS];
      px_s0  <= 51'(m0) * 51'(K_A);
      neg_s1 <= neg_s0;
      x_s1   <= 27'((px_s0 + ROUND24) >> INT_Q);
    end
  end

  // S2: x = n*ln2 + r
  logic [2:0]  n_c;
  logic [23:0] r_c;

  always_comb begin
    n_c = '0;
    for (int k = 1; k < 8; k++) begin
      if (x_s1 >= LN2_MULT[k]) n_c = n_c + 3'd1;
    end
  end
  assign r_c = 24'(x_s1 - LN2_MULT[n_c]);

  logic [24:0] term_t [0:NT];
  logic [25:0] er_t   [0:NT];
  logic [23:0] r_t    [0:NT];
  logic [2:0]  n_t    [0:NT];
  logic        neg_t  [0:NT];

  always_ff @(posedge clk) begin
    if (en) begin
      term_t[0] <= 25'd1 << INT_Q;
      er_t[0]   <= '0;
      r_t[0]    <= r_c;
      n_t[0]    <= n_c;
      neg_t[0]  <= neg_s1;
    end
  end

  // Taylor terms: multiply, then divide by k
  logic [48:0] prod_a [1:NT];
  logic [25:0] er_a   [1:NT];
  logic [23:0] r_a    [1:NT];
  logic [2:0]  n_a    [1:NT];
  logic        neg_a  [1:NT];

  for (genvar k = 1; k <= NT; k++) begin : g_taylor
    always_ff @(posedge clk) begin
      if (en) begin
        prod_a[k] <= 49'(term_t[k-1]) * 49'(r_t[k-1]);
        er_a[k]   <= er_t[k-1] + 26'(term_t[k-1]);
        r_a[k]    <= r_t[k-1];
        n_a[k]    <= n_t[k-1];
        neg_a[k]  <= neg_t[k-1];
        term_t[k] <= 25'((56'(prod_a[k][48:24]) * 56'(DIV_RECIP[k])) >> RECIP_SHIFT);
        er_t[k]   <= er_a[k];
        r_t[k]    <= r_a[k];
        n_t[k]    <= n_a[k];
        neg_t[k]  <= neg_a[k];
      end
    end
  end

  // reciprocal: round(2^48 / er), one quotient bit a stage
  logic [24:0] rem_d [0:ND];
  logic [24:0] quo_d [0:ND];
  logic [24:0] den_d [0:ND];
  logic [2:0]  n_d   [0:ND];
  logic        neg_d [0:ND];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_d[0] <= 25'd1 << 23;
      quo_d[0] <= '0;
      den_d[0] <= 25'(er_t[NT] + 26'(term_t[NT]));
      n_d[0]   <= n_t[NT];
      neg_d[0] <= neg_t[NT];
    end
  end

  for (genvar i = 1; i <= ND; i++) begin : g_div
    logic        nbit, ge;
    logic [25:0] rem2;
    assign nbit = (i == 1) ? 1'b0 : den_d[i-1][(i == 1) ? 0 : ND + 1 - i];
    assign rem2 = {rem_d[i-1], nbit};
    assign ge   = rem2 >= {1'b0, den_d[i-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_d[i] <= ge ? 25'(rem2 - {1'b0, den_d[i-1]}) : 25'(rem2);
        quo_d[i] <= {quo_d[i-1][23:0], ge};
        den_d[i] <= den_d[i-1];
        n_d[i]   <= n_d[i-1];
        neg_d[i] <= neg_d[i-1];
      end
    end
  end

  // tail: scale, sinh/cosh, gains, rounding, sign
  logic [31:0] e_h, ch_h;
  logic [24:0] einv_h;
  logic [30:0] sh_h;
  logic [49:0] pk;
  logic [53:0] ps;
  logic [25:0] ak;
  logic [29:0] as_r;
  logic        neg_h1, neg_h2, neg_h3, neg_h4;
  logic [25:0] bk;

  assign bk = 26'((27'(ak) + 27'(HALF)) >> SH_DOWN);

  always_ff @(posedge clk) begin
    if (en) begin
      e_h    <= 32'({7'd0, den_d[ND]} << n_d[ND]);
      einv_h <= 25'((26'(quo_d[ND]) + ((26'd1 << n_d[ND]) >> 1)) >> n_d[ND]);
      neg_h1 <= neg_d[ND];
      sh_h   <= 31'((33'(e_h) - 33'(einv_h)) >> 1);
      ch_h   <= 32'((33'(e_h) + 33'(einv_h)) >> 1);
      neg_h2 <= neg_h1;
      pk     <= 50'(sh_h) * 50'(K_K);
      ps     <= 54'(ch_h) * 54'(K_AK);
      neg_h3 <= neg_h2;
      ak     <= 26'((pk + 50'(ROUND24)) >> INT_Q);
      as_r   <= 30'((ps + 54'(ROUND24)) >> INT_Q);
      neg_h4 <= neg_h3;
      tau    <= neg_h4 ? $signed(32'(bk)) : -$signed(32'(bk));
      stiff  <= 32'((31'(as_r) + 31'(HALF)) >> SH_DOWN);
    end
  end

endmodule

`default_nettype wire

// File: design/ejt_back.sv
// ----------------------------------------------------------------------------
// ejt_back: execution pipeline
// Two spring lanes, a side line for the pass-through fields, the held spring
// values, the torque sums and the saturating output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ejt_back import ejt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int QW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  logic [QW-1:0] head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [159:0]  out_word
);

  localparam int DAMP_W = 63 - FRAC_BITS;
  localparam int TQ_W   = 64 - FRAC_BITS;
  localparam int AP_W   = 65 - FRAC_BITS;
  localparam int DW     = FRAC_BITS + 1;
  localparam int L      = SPRING_LAT;

  logic en;

  // whole pipeline moves while the output register can take a word
  assign en  = !out_valid || out_ready;
  assign pop = en && head_valid;

  // unpack the queue word
  logic signed [31:0]       h_ext, h_r1;
  logic signed [DAMP_W-1:0] h_damp;
  logic signed [DW-1:0]     h_d1, h_d2;
  logic                     h_direct;

  assign h_ext    = head[31:0];
  assign h_r1     = head[63:32];
  assign h_damp   = head[64 +: DAMP_W];
  assign h_d2     = head[64 + DAMP_W +: DW];
  assign h_d1     = head[64 + DAMP_W + DW +: DW];
  assign h_direct = head[QW-1];

  logic signed [31:0] tau1, tau2;
  logic [31:0]        stf1, stf2;

  ejt_spring #(.FRAC_BITS(FRAC_BITS)) u_spring_one (
    .clk(clk), .en(en), .defl(h_d1), .tau(tau1), .stiff(stf1)
  );

  ejt_spring #(.FRAC_BITS(FRAC_BITS)) u_spring_two (
    .clk(clk), .en(en), .defl(h_d2), .tau(tau2), .stiff(stf2)
  );

  // side line, same depth as the spring lanes
  logic                     vld_l    [0:L-1];
  logic                     direct_l [0:L-1];
  logic signed [DAMP_W-1:0] damp_l   [0:L-1];
  logic signed [31:0]       r1_l     [0:L-1];
  logic signed [31:0]       ext_l    [0:L-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < L; i++) vld_l[i] <= 1'b0;
    end else if (en) begin
      vld_l[0] <= head_valid;
      for (int i = 1; i < L; i++) vld_l[i] <= vld_l[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      direct_l[0] <= h_direct;
      damp_l[0]   <= h_damp;
      r1_l[0]     <= h_r1;
      ext_l[0]    <= h_ext;
      for (int i = 1; i < L; i++) begin
        direct_l[i] <= direct_l[i-1];
        damp_l[i]   <= damp_l[i-1];
        r1_l[i]     <= r1_l[i-1];
        ext_l[i]    <= ext_l[i-1];
      end
    end
  end

  // held spring values
  logic signed [31:0] held_t1, held_t2;
  logic [31:0]        held_s1, held_s2;
  logic signed [31:0] t1_c, t2_c;
  logic [31:0]        s1_c, s2_c;
  logic signed [TQ_W-1:0] base_c, torque_c;
  logic               dir_end;

  assign dir_end  = direct_l[L-1];
  assign t1_c     = dir_end ? held_t1 : tau1;
  assign t2_c     = dir_end ? held_t2 : tau2;
  assign s1_c     = dir_end ? held_s1 : stf1;
  assign s2_c     = dir_end ? held_s2 : stf2;
  assign base_c   = dir_end ? TQ_W'(r1_l[L-1]) : TQ_W'(t1_c) + TQ_W'(t2_c);
  assign torque_c = base_c - TQ_W'(damp_l[L-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_t1 <= '0;
      held_t2 <= '0;
      held_s1 <= '0;
      held_s2 <= '0;
    end else if (en && vld_l[L-1] && !dir_end) begin
      held_t1 <= tau1;
      held_t2 <= tau2;
      held_s1 <= stf1;
      held_s2 <= stf2;
    end
  end

  // sum stage
  logic                   vld_f;
  logic signed [TQ_W-1:0] torque_f;
  logic [32:0]            stiff_f;
  logic signed [31:0]     t1_f, t2_f, ext_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_f <= 1'b0;
    end else if (en) begin
      vld_f <= vld_l[L-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      torque_f <= torque_c;
      stiff_f  <= 33'(s1_c) + 33'(s2_c);
      t1_f     <= t1_c;
      t2_f     <= t2_c;
      ext_f    <= ext_l[L-1];
    end
  end

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // output register
  logic signed [AP_W-1:0] applied_c;
  assign applied_c = AP_W'(torque_f) - AP_W'(ext_f);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld_f;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word <= {t2_f, t1_f, sat32(64'($signed({1'b0, stiff_f}))),
                   sat32(64'(torque_f)), sat32(64'(applied_c))};
    end
  end

endmodule

`default_nettype wire

// File: design/ejt_checker.sv
// ----------------------------------------------------------------------------
// ejt_checker: port-level checks
// Reset behaviour of both channels and output hold under back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module ejt_checker (
  input wire         clk,
  input wire         rst,
  input wire         s_axis_tready,
  input wire         m_axis_tvalid,
  input wire         m_axis_tready,
  input wire [159:0] m_axis_tdata
);

  // no result word survives a reset
  a_rst_out: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result word valid after reset");

  // queue and front are empty after reset, so input is taken
  a_rst_rdy: assert property (@(posedge clk) rst |=> s_axis_tready)
    else $error("input not ready after reset");

  // stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result word changed");

endmodule

bind elastic_joint_torque_model ejt_checker u_ejt_checker (.*);

`default_nettype wire
